// ===== src/mrsp_pkg.sv =====
package mrsp_pkg;

    // message kinds on the result side
    typedef enum logic [2:0] {
        KIND_NOTE_ON    = 3'd0,
        KIND_NOTE_OFF   = 3'd1,
        KIND_CONTROLLER = 3'd2,
        KIND_PROGRAM    = 3'd3,
        KIND_PITCH_BEND = 3'd4
    } t_kind;

    // status high nibbles
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_CONTROLLER = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    // bytes 0xF8 and above are real-time
    localparam logic [7:0] REALTIME_MIN = 8'hF8;

    localparam int unsigned RES_BITS  = 21;
    localparam int unsigned TDATA_OUT = 24;

    // one decoded message, packed last field in the lowest bits
    typedef struct packed {
        logic [6:0] data_second;
        logic [6:0] data_first;
        logic [3:0] channel;
        t_kind      msg_kind;
    } t_result;

    // decoder to output buffer
    typedef struct packed {
        logic    vld;
        t_result res;
    } t_res_push;

endpackage

// ===== src/midi_running_status_parser.sv =====
// A result is valid once the byte that completes it has passed the input
// register and then the result queue register; a byte that completes no
// message gives no result.
// Throughput: one byte per cycle while the two-entry result queue has room.
// Reset (i_rst_n low, synchronous) drops held status and counters and
// empties the input register and the result queue.
module midi_running_status_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] midi_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [2:0] msg_kind, [6:3] channel,
                                     // [13:7] data_first, [20:14] data_second
);

    logic                r_in_vld, n_in_vld;
    logic [7:0]          r_in_byte;
    logic                adv;
    logic                space;
    mrsp_pkg::t_res_push push;
    mrsp_pkg::t_result   res;

    // input register advances when the queue has room
    assign adv        = r_in_vld && space;
    assign o_s_tready = !r_in_vld || space;
    assign n_in_vld   = (i_s_tvalid && o_s_tready) ? 1'b1 : (adv ? 1'b0 : r_in_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    mrsp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    mrsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_res   (res)
    );

    // pack result, zero pad to whole bytes
    assign o_m_tdata = {{(mrsp_pkg::TDATA_OUT - mrsp_pkg::RES_BITS){1'b0}}, res};

endmodule

// ===== src/mrsp_decode.sv =====
module mrsp_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [7:0]          i_byte,
    output mrsp_pkg::t_res_push o_push
);

    logic [7:0] r_held_status, n_held_status;
    logic [1:0] r_bytes_needed, n_bytes_needed;
    logic [1:0] r_bytes_got, n_bytes_got;
    logic [6:0] r_first_data, n_first_data;

    logic       emit_req;
    logic [6:0] emit_d1;
    logic [6:0] emit_d2;
    logic [3:0] held_hi;

    assign held_hi = r_held_status[7:4];

    // parser state update
    always_comb begin
        n_held_status  = r_held_status;
        n_bytes_needed = r_bytes_needed;
        n_bytes_got    = r_bytes_got;
        n_first_data   = r_first_data;
        emit_req       = 1'b0;
        emit_d1        = i_byte[6:0];
        emit_d2        = 7'd0;
        if (i_adv) begin
            priority if (i_byte >= mrsp_pkg::REALTIME_MIN) begin
                // real-time: nothing changes
            end else if (i_byte[7] && i_byte[7:4] == mrsp_pkg::HI_SYSTEM) begin
                n_held_status = 8'd0;
            end else if (i_byte[7]) begin
                n_held_status  = i_byte;
                n_bytes_got    = 2'd0;
                n_bytes_needed = (i_byte[7:4] == mrsp_pkg::HI_PROGRAM ||
                                  i_byte[7:4] == mrsp_pkg::HI_PRESSURE) ? 2'd1 : 2'd2;
            end else if (r_held_status == 8'd0) begin
                // data with no status: dropped
            end else if (r_bytes_needed == 2'd1) begin
                n_bytes_got = 2'd0;
                emit_req    = 1'b1;
            end else if (r_bytes_got == 2'd0) begin
                n_first_data = i_byte[6:0];
                n_bytes_got  = 2'd1;
            end else begin
                n_bytes_got = 2'd0;
                emit_req    = 1'b1;
                emit_d1     = r_first_data;
                emit_d2     = i_byte[6:0];
            end
        end
    end

    // result formation by status kind
    always_comb begin
        o_push.vld             = 1'b0;
        o_push.res.channel     = r_held_status[3:0];
        o_push.res.data_first  = emit_d1;
        o_push.res.data_second = emit_d2;
        o_push.res.msg_kind    = mrsp_pkg::KIND_NOTE_OFF;
        unique case (held_hi)
            mrsp_pkg::HI_NOTE_ON: begin
                o_push.vld          = emit_req;
                o_push.res.msg_kind = (emit_d2 != 7'd0) ? mrsp_pkg::KIND_NOTE_ON
                                                        : mrsp_pkg::KIND_NOTE_OFF;
            end
            mrsp_pkg::HI_NOTE_OFF: begin
                o_push.vld          = emit_req;
                o_push.res.msg_kind = mrsp_pkg::KIND_NOTE_OFF;
            end
            mrsp_pkg::HI_CONTROLLER: begin
                o_push.vld          = emit_req;
                o_push.res.msg_kind = mrsp_pkg::KIND_CONTROLLER;
            end
            mrsp_pkg::HI_PROGRAM: begin
                o_push.vld             = emit_req;
                o_push.res.msg_kind    = mrsp_pkg::KIND_PROGRAM;
                o_push.res.data_second = 7'd0;
            end
            mrsp_pkg::HI_PITCH_BEND: begin
                o_push.vld          = emit_req;
                o_push.res.msg_kind = mrsp_pkg::KIND_PITCH_BEND;
            end
            default: begin
                // aftertouch and channel pressure complete silently
                o_push.vld = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_status  <= 8'd0;
            r_bytes_needed <= 2'd0;
            r_bytes_got    <= 2'd0;
            r_first_data   <= 7'd0;
        end else begin
            r_held_status  <= n_held_status;
            r_bytes_needed <= n_bytes_needed;
            r_bytes_got    <= n_bytes_got;
            r_first_data   <= n_first_data;
        end
    end

endmodule

// ===== src/mrsp_out_buf.sv =====
module mrsp_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrsp_pkg::t_res_push i_push,
    output logic                o_space,
    output logic                o_vld,
    input  logic                i_rdy,
    output mrsp_pkg::t_result   o_res
);

    // two-entry result queue; space is a registered count compare
    mrsp_pkg::t_result r_mem [2];
    logic              r_wptr, n_wptr;
    logic              r_rptr, n_rptr;
    logic [1:0]        r_cnt, n_cnt;
    logic              push_en;
    logic              pop_en;

    assign o_space = (r_cnt != 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rptr];
    assign push_en = i_push.vld && o_space;
    assign pop_en  = o_vld && i_rdy;

    // pointer and count update
    always_comb begin
        n_wptr = push_en ? ~r_wptr : r_wptr;
        n_rptr = pop_en  ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt;
        unique case ({push_en, pop_en})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wptr] <= i_push.res;
        end
    end

endmodule
